// ===== src/tdpt_pkg.sv =====
// Shared command and status types for the trial-division prime test.
`default_nettype none

package tdpt_pkg;

    // Width of the candidate field on the input port.
    localparam int CAND_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new candidate, reset divisor to two
        logic div_start;  // begin a remainder pass for the current divisor
        logic div_step;   // one restoring remainder bit
        logic advance;    // move to the next divisor
        logic finish;     // register the verdict and strobe it
        logic prime;      // verdict that goes with finish
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt_two;     // candidate is zero or one
        logic sq_gt_n;    // divisor squared exceeds the candidate
        logic div_last;   // final bit of the remainder pass
        logic rem_zero;   // remainder of the last pass is zero
    } t_dp_status;

endpackage : tdpt_pkg

`default_nettype wire

// ===== src/trial_division_prime_test_core.sv =====
// Top level of the trial-division prime test: controller plus datapath.
//   Divisors are tried in turn from two until one divides or its square exceeds the
//   candidate; none is tried for zero to three. Each divisor takes one square check,
//   a remainder pass over all VALUE_WIDTH candidate bits and one zero test. One beat
//   at a time; busy drops with the strobe.
//   Reset: synchronous, active low; returns the controller to idle, clears the strobe.
`default_nettype none

module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tdpt_pkg::CAND_W-1:0] i_candidate,
    output logic                             o_result_valid,
    output logic                             o_is_prime
);
    import tdpt_pkg::*;

    // Commands and status run only between controller and datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequence: load the beat, check the square bound, run one remainder pass per divisor,
    // and stop for a candidate below two, at the first zero remainder or once past the root.
    tdpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // Hold the candidate, the divisor and its square; compute the remainder bit by bit.
    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_candidate    (i_candidate),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_is_prime     (o_is_prime)
    );

endmodule : trial_division_prime_test_core

`default_nettype wire

// ===== src/tdpt_ctrl.sv =====
// Controller state machine for the trial-division prime test.
`default_nettype none

module tdpt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output tdpt_pkg::t_dp_cmd         o_cmd,
    input  wire tdpt_pkg::t_dp_status i_status
);
    import tdpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_TEST  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.lt_two) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.prime  = 1'b0;
                    n_state      = S_IDLE;
                end else if (i_status.sq_gt_n) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.prime  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.rem_zero) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.prime  = 1'b0;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule : tdpt_ctrl

`default_nettype wire

// ===== src/tdpt_datapath.sv =====
// Datapath: held candidate, divisor, running square and bit-serial remainder unit.
`default_nettype none

module tdpt_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tdpt_pkg::CAND_W-1:0]  i_candidate,
    input  wire tdpt_pkg::t_dp_cmd            i_cmd,
    output tdpt_pkg::t_dp_status              o_status,
    output logic                              o_result_valid,
    output logic                              o_is_prime
);
    import tdpt_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     w_cand;
    logic [W-1:0]     r_cand;
    logic [W-1:0]     r_div;
    logic [W+1:0]     r_sq;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_shift;
    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    logic             r_prime;

    logic [W:0]       w_trial;
    logic [W-1:0]     w_rem_next;

    // Fit the candidate to the working width.
    if (W <= CAND_W) begin : g_trunc
        assign w_cand = i_candidate[W-1:0];
    end else begin : g_ext
        assign w_cand = {{(W - CAND_W){1'b0}}, i_candidate};
    end

    // Restoring remainder: shift in the next candidate bit, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_shift[W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_rem_next = W'(w_trial - {1'b0, r_div});
        end else begin
            w_rem_next = w_trial[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand <= w_cand;
            r_div  <= W'(2);
            r_sq   <= (W + 2)'(4);
        end
        if (i_cmd.advance) begin
            r_div <= r_div + W'(1);
            r_sq  <= r_sq + {1'b0, r_div, 1'b1};
        end
        if (i_cmd.div_start) begin
            r_rem   <= '0;
            r_shift <= r_cand;
            r_cnt   <= CNT_W'(W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_rem_next;
            r_shift <= {r_shift[W-2:0], 1'b0};
            r_cnt   <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_prime <= i_cmd.prime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_status.lt_two   = (r_cand[W-1:1] == '0);
    assign o_status.sq_gt_n  = (r_sq > {2'b00, r_cand});
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.rem_zero = (r_rem == '0);

    assign o_result_valid = r_valid;
    assign o_is_prime     = r_prime;

endmodule : tdpt_datapath

`default_nettype wire

// ===== src/tdpt_checker.sv =====
// Port-level assertions for the prime test core, bound to the top level.
`default_nettype none

module tdpt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_valid,
    input wire logic o_is_prime
);

    // An accepted beat always occupies the core on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a beat");

    // The result strobe shows only once the core is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // A strobe lasts one cycle, and no two strobes come back to back.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // The core leaves busy only by delivering a result.
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_result_valid && !$isunknown(o_is_prime)))
        else $error("busy dropped without a result");

endmodule : tdpt_checker

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_is_prime     (o_is_prime)
);

`default_nettype wire
